[rtl/ppr_pkg.sv]
// Shared types and constants for the polar parameter ramp bank.
// No dependencies; ppr_ctrl, ppr_dp and the top level import this package.
package ppr_pkg;

  // Default bank size and value resolution
  localparam int unsigned SOURCES_DEF    = 8;
  localparam int unsigned VALUE_BITS_DEF = 24;

  // Ramp length after reset, in ticks
  localparam logic [15:0] RAMP_LEN_RST = 16'd4410;

  // Results per tick are capped at this many sources
  localparam int unsigned MAX_OUT = 8;

  // Quotient bits of the step divider (magnitude of a 33-bit difference)
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned DIV_CNT_W = 6;

  // Operation codes of an input word
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_RAMP_RAD = 3'd1,
    OP_RAMP_AZ  = 3'd2,
    OP_SET_RAD  = 3'd3,
    OP_SET_AZ   = 3'd4
  } op_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;       // latch the input word
    logic tick_start; // decide snap, advance the tick counter
    logic tick_wr;    // advance one entry and write it back
    logic is_az;      // entry in work is an azimuth
    logic emit;       // load the output register
    logic last;       // final result of this tick
    logic direct_wr;  // write value as current and target, zero step
    logic div_init;   // take the difference, start the divider
    logic div_step;   // one restoring division step
    logic ramp_wr;    // write target and quotient step
  } ppr_cmd_t;

endpackage

[rtl/ppr_ram.sv]
// Generic single write port RAM with a registered read port.
// No dependencies.
module ppr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/ppr_ctrl.sv]
// Sequencer of the ramp bank: walks the entries on a tick, runs set operations.
// Depends on ppr_pkg.
module ppr_ctrl #(
  parameter int unsigned SOURCES = ppr_pkg::SOURCES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       operation_i,
  input  logic [2:0]                       source_index_i,
  input  logic                             out_free_i,
  output ppr_pkg::ppr_cmd_t                cmd_o,
  output logic [$clog2(2*SOURCES)-1:0]     entry_o,
  output logic [(SOURCES > 1 ? $clog2(SOURCES) : 1)-1:0] src_o
);
  import ppr_pkg::*;

  localparam int unsigned AW   = $clog2(2 * SOURCES);
  localparam int unsigned SW   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int unsigned NOUT = (SOURCES < MAX_OUT) ? SOURCES : MAX_OUT;

  typedef enum logic [3:0] {
    ST_IDLE, ST_T_RR, ST_T_RW, ST_T_AR, ST_T_AW,
    ST_S_RD, ST_S_RDW, ST_S_DIV, ST_S_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [SW-1:0]        src_q, src_d;
  logic [2:0]           op_q, op_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 accept, valid_op, emit_here, is_az_set, is_ramp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign valid_op   = (operation_i == OP_RAMP_RAD) || (operation_i == OP_RAMP_AZ) ||
                      (operation_i == OP_SET_RAD) || (operation_i == OP_SET_AZ);
  assign emit_here  = (7'(src_q) < 7'(NOUT));
  assign is_az_set  = (op_q == OP_RAMP_AZ) || (op_q == OP_SET_AZ);
  assign is_ramp    = (op_q == OP_RAMP_RAD) || (op_q == OP_RAMP_AZ);
  assign src_o      = src_q;

  // Pick the entry: radii first, azimuths above them
  always_comb begin
    logic az;
    az = 1'b0;
    case (state_q)
      ST_T_AR, ST_T_AW: az = 1'b1;
      ST_S_RD, ST_S_RDW, ST_S_DIV, ST_S_FIN: az = is_az_set;
      default: az = 1'b0;
    endcase
    entry_o = AW'(src_q) + (az ? AW'(SOURCES) : AW'(0));
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    src_d   = src_q;
    op_d    = op_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i;
          if (operation_i == OP_TICK) begin
            cmd_o.tick_start = 1'b1;
            src_d   = '0;
            state_d = ST_T_RR;
          end else if (valid_op && (7'(source_index_i) < 7'(SOURCES))) begin
            cmd_o.load = 1'b1;
            src_d   = SW'(source_index_i);
            state_d = ST_S_RD;
          end
        end
      end
      ST_T_RR: state_d = ST_T_RW;
      ST_T_RW: begin
        cmd_o.tick_wr = 1'b1;
        state_d = ST_T_AR;
      end
      ST_T_AR: state_d = ST_T_AW;
      ST_T_AW: begin
        if (!emit_here || out_free_i) begin
          cmd_o.tick_wr = 1'b1;
          cmd_o.is_az   = 1'b1;
          cmd_o.emit    = emit_here;
          cmd_o.last    = (src_q == SW'(NOUT - 1));
          if (src_q == SW'(SOURCES - 1)) begin
            state_d = ST_IDLE;
          end else begin
            src_d   = src_q + SW'(1);
            state_d = ST_T_RR;
          end
        end
      end
      ST_S_RD: state_d = ST_S_RDW;
      ST_S_RDW: begin
        cmd_o.is_az = is_az_set;
        if (is_ramp) begin
          cmd_o.div_init = 1'b1;
          cnt_d   = '0;
          state_d = ST_S_DIV;
        end else begin
          cmd_o.direct_wr = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_S_FIN;
        end
      end
      ST_S_FIN: begin
        cmd_o.is_az   = is_az_set;
        cmd_o.ramp_wr = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (!accept && state_q == ST_IDLE) begin
      cmd_o = '0;
    end
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      src_q   <= '0;
      op_q    <= OP_TICK;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      src_q   <= src_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/ppr_dp.sv]
// Datapath of the ramp bank: entry store, accumulate, shortest-path difference,
// restoring step divider, tick counter and output register. Depends on ppr_pkg, ppr_ram.
module ppr_dp #(
  parameter int unsigned SOURCES    = ppr_pkg::SOURCES_DEF,
  parameter int unsigned VALUE_BITS = ppr_pkg::VALUE_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  ppr_pkg::ppr_cmd_t                             cmd_i,
  input  logic [$clog2(2*SOURCES)-1:0]                  entry_i,
  input  logic [(SOURCES > 1 ? $clog2(SOURCES) : 1)-1:0] src_i,
  input  logic [23:0]                                   value_i,
  input  logic                                          cfg_we_i,
  input  logic [15:0]                                   cfg_wdata_i,
  output logic                                          out_free_o,
  output logic                                          out_valid_o,
  input  logic                                          out_stall_i,
  output logic [2:0]                                    out_source_o,
  output logic signed [23:0]                            radius_now_o,
  output logic [23:0]                                   azimuth_now_o,
  output logic                                          last_o
);
  import ppr_pkg::*;

  localparam int unsigned ALIGN = 32 - VALUE_BITS;
  localparam int unsigned W     = 64 + VALUE_BITS;

  logic [15:0]           ramp_len_q, div_val;
  logic [15:0]           tcnt_q;
  logic                  snap_q;
  logic [VALUE_BITS-1:0] word_q;
  logic [31:0]           aligned, val_ext;
  logic [2*SOURCES-1:0]  valid_q;
  logic                  rd_valid_q;
  logic [W-1:0]          rdata, wdata;
  logic                  we;
  logic [31:0]           cur, stp, snap_val, new_cur, new_stp, rad_q, hold_q;
  logic [VALUE_BITS-1:0] tgt;
  logic signed [32:0]    rsum;
  logic signed [33:0]    diff, qs;
  logic [32:0]           mag_q;
  logic [15:0]           rem_q;
  logic                  neg_q;
  logic [16:0]           rem2;
  logic                  ge;
  logic [31:0]           step_q;
  logic                  out_valid_q, last_q;
  logic [2:0]            out_src_q;
  logic [31:0]           out_rad_q, out_az_q;

  assign div_val = (ramp_len_q == 16'd0) ? 16'd1 : ramp_len_q;
  assign val_ext = {8'd0, value_i};
  assign aligned = 32'(word_q) << ALIGN;

  // Entry store: current, target, step
  ppr_ram #(.WIDTH(W), .DEPTH(2 * SOURCES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (entry_i),
    .wdata_i (wdata),
    .raddr_i (entry_i),
    .rdata_o (rdata)
  );

  // An entry never written reads as zero
  assign cur = rd_valid_q ? rdata[W-1 -: 32] : 32'd0;
  assign tgt = rd_valid_q ? rdata[32 +: VALUE_BITS] : '0;
  assign stp = rd_valid_q ? rdata[31:0] : 32'd0;

  // Advance one entry, saturating radius, wrapping azimuth; on a snap, take the target and zero the step
  assign rsum     = {cur[31], cur} + {stp[31], stp};
  assign snap_val = 32'(tgt) << ALIGN;
  always_comb begin
    if (cmd_i.is_az) begin
      new_cur = cur + stp;
    end else if (rsum[32] != rsum[31]) begin
      new_cur = rsum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      new_cur = rsum[31:0];
    end
    new_stp = stp;
    if (snap_q) begin
      new_cur = snap_val;
      new_stp = 32'd0;
    end
  end

  // Difference to target, shortest way round for azimuth
  always_comb begin
    if (cmd_i.is_az) begin
      diff = $signed({2'b00, aligned}) - $signed({2'b00, cur});
      if (diff > 34'sh0_8000_0000) begin
        diff = diff - 34'sh1_0000_0000;
      end else if (diff < -34'sh0_8000_0000) begin
        diff = diff + 34'sh1_0000_0000;
      end
    end else begin
      diff = $signed({{2{aligned[31]}}, aligned}) - $signed({{2{cur[31]}}, cur});
    end
  end

  // One restoring division step
  assign rem2 = {rem_q, mag_q[32]};
  assign ge   = (rem2 >= {1'b0, div_val});

  // Signed quotient, saturated for radius, wrapped for azimuth
  assign qs = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  always_comb begin
    if (cmd_i.is_az) begin
      step_q = qs[31:0];
    end else if (qs > 34'sh0_7FFF_FFFF) begin
      step_q = 32'h7FFF_FFFF;
    end else if (qs < -34'sh0_8000_0000) begin
      step_q = 32'h8000_0000;
    end else begin
      step_q = qs[31:0];
    end
  end

  // Write-back data
  assign we = cmd_i.tick_wr | cmd_i.direct_wr | cmd_i.ramp_wr;
  always_comb begin
    if (cmd_i.direct_wr) begin
      wdata = {aligned, word_q, 32'd0};
    end else if (cmd_i.ramp_wr) begin
      wdata = {hold_q, word_q, step_q};
    end else begin
      wdata = {new_cur, tgt, new_stp};
    end
  end

  // Control state: ramp length, tick counter, valid bits, output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_len_q  <= RAMP_LEN_RST;
      tcnt_q      <= '0;
      snap_q      <= 1'b0;
      valid_q     <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ramp_len_q <= cfg_wdata_i;
      end
      if (cmd_i.tick_start) begin
        snap_q <= (tcnt_q >= div_val);
        tcnt_q <= (tcnt_q >= div_val) ? 16'd0 : tcnt_q + 16'd1;
      end
      if (cmd_i.direct_wr || cmd_i.ramp_wr) begin
        tcnt_q <= 16'd0;
      end
      if (we) begin
        valid_q[entry_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[entry_i];
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: input word, divider, result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= val_ext[VALUE_BITS-1:0];
    end
    if (cmd_i.div_init) begin
      hold_q <= cur;
      neg_q  <= diff[33];
      mag_q  <= diff[33] ? 33'(-diff) : diff[32:0];
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= ge ? 16'(rem2 - {1'b0, div_val}) : rem2[15:0];
      mag_q  <= {mag_q[31:0], ge};
    end
    if (cmd_i.tick_wr && !cmd_i.is_az) begin
      rad_q <= new_cur;
    end
    if (cmd_i.emit) begin
      out_src_q <= 3'(src_i);
      out_rad_q <= 32'($signed(rad_q) >>> ALIGN);
      out_az_q  <= new_cur >> ALIGN;
      last_q    <= cmd_i.last;
    end
  end

  assign out_free_o    = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign out_source_o  = out_src_q;
  assign radius_now_o  = out_rad_q[23:0];
  assign azimuth_now_o = out_az_q[23:0];
  assign last_o        = last_q;

endmodule

[rtl/polar_parameter_ramp_bank.sv]
// Polar parameter ramp bank: SOURCES radius/azimuth pairs ramping linearly to targets.
// A tick reads then writes the radius and then the azimuth entry of each source in turn,
// waiting at each emitted word while the output is stalled; it gives one word per source, up to eight.
// A direct set reads the entry and writes it back; a ramp set runs the 33-step serial divider between.
// Depends on ppr_pkg, ppr_ctrl, ppr_dp and ppr_ram.
module polar_parameter_ramp_bank #(
  parameter int unsigned SOURCES    = ppr_pkg::SOURCES_DEF,
  parameter int unsigned VALUE_BITS = ppr_pkg::VALUE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [2:0]         source_index_i,
  input  logic [23:0]        value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_source_o,
  output logic signed [23:0] radius_now_o,
  output logic [23:0]        azimuth_now_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);
  import ppr_pkg::*;

  localparam int unsigned AW = $clog2(2 * SOURCES);
  localparam int unsigned SW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  ppr_cmd_t      cmd;
  logic [AW-1:0] entry;
  logic [SW-1:0] src;
  logic          out_free;

  ppr_ctrl #(.SOURCES(SOURCES)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .source_index_i (source_index_i),
    .out_free_i     (out_free),
    .cmd_o          (cmd),
    .entry_o        (entry),
    .src_o          (src)
  );

  ppr_dp #(.SOURCES(SOURCES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .entry_i       (entry),
    .src_i         (src),
    .value_i       (value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_free_o    (out_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_source_o  (out_source_o),
    .radius_now_o  (radius_now_o),
    .azimuth_now_o (azimuth_now_o),
    .last_o        (last_o)
  );

endmodule
